FILE: src/wgm_pkg.sv
package wgm_pkg;

    localparam int REG_ELEMENTS = 16;
    localparam int PATTERN_ELEMENTS_DEF = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_LOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KINDS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 2'd3;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ONE     = 2'd1,
        KIND_RUN     = 2'd2
    } kind_t;

    // Signals handed from one cell to the next within the same cycle.
    typedef struct packed {
        logic cur_carry;
        logic step;
        logic nc_carry;
    } link_t;

endpackage

FILE: src/wildcard_glob_matcher_unit.sv
// Wildcard glob matcher. Text bytes enter on the s_ channel, one item per byte,
// with s_tlast marking the final byte of a text. For every byte one result item
// leaves on the m_ channel: m_tdata[0] tells whether the whole pattern matches
// the text seen so far, and m_tlast echoes the input's tlast.
// The pattern is written through the cfg_ channel, which is always ready:
// index 0 and 1 hold the literal bytes, index 2 the two-bit element kinds and
// index 3 the number of elements in use. Write it only while no text is in flight.
// Each result is registered and appears in the cycle after its byte is taken, and
// one byte is taken every cycle unless a result stalls. The active set lives in a row
// of cells, one per pattern element, and the per-byte update ripples once along that
// row within the cycle. While a result waits for m_tready, the output register holds
// it and s_tready drops; taking the result frees the input in the same cycle.
// Reset clears the pattern to empty and sets the active set to the start position.
// After a byte marked last the active set returns to the start position.
module wildcard_glob_matcher_unit #(
    parameter int PATTERN_ELEMENTS = wgm_pkg::PATTERN_ELEMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] text_byte
    input  logic                               s_tlast,   // end_of_text
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [0] matched, [7:1] zero
    output logic                               m_tlast,   // text_done
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wgm_pkg::*;

    localparam int N = (PATTERN_ELEMENTS < REG_ELEMENTS) ? PATTERN_ELEMENTS : REG_ELEMENTS;
    localparam int LW = $clog2(N + 1);

    logic [63:0]   bytes_low_reg;
    logic [63:0]   bytes_high_reg;
    logic [31:0]   kinds_reg;
    logic [4:0]    length_reg;
    logic [LW-1:0] eff_len;

    logic          accept;
    logic          top_reg;
    logic          top_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          matched_reg;
    logic          matched_next;
    logic          done_reg;
    logic          done_next;

    logic [127:0]  pattern_bytes;
    logic [N:0]    nxt_vec;
    logic [N:0]    act_vec;
    link_t         links [N+1];

    assign cfg_ready = 1'b1;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;
    assign pattern_bytes = {bytes_high_reg, bytes_low_reg};

    always_comb
    begin
        if (int'(length_reg) > N)
        begin
            eff_len = LW'(N);
        end
        else
        begin
            eff_len = length_reg[LW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_low_reg <= '0;
            bytes_high_reg <= '0;
            kinds_reg <= '0;
            length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BYTES_LOW:  bytes_low_reg <= cfg_data;
                REG_BYTES_HIGH: bytes_high_reg <= cfg_data;
                REG_KINDS:      kinds_reg <= cfg_data[31:0];
                REG_LENGTH:     length_reg <= cfg_data[4:0];
                default:        length_reg <= length_reg;
            endcase
        end
    end

    assign links[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        wgm_cell #(
            .START_BIT((i == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (accept),
            .restart  (s_tlast),
            .elem_en  (int'(eff_len) > i),
            .pos_en   (int'(eff_len) >= i),
            .kind     (kind_t'(kinds_reg[2*i +: 2])),
            .elem_byte(pattern_bytes[8*i +: 8]),
            .text_byte(s_tdata),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .moved_pos(nxt_vec[i]),
            .state    (act_vec[i])
        );
    end

    assign nxt_vec[N] = links[N].step | links[N].nc_carry;
    assign act_vec[N] = top_reg;

    always_comb
    begin
        top_next = top_reg;
        out_valid_next = out_valid_reg;
        matched_next = matched_reg;
        done_next = done_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            top_next = s_tlast ? 1'b0 : nxt_vec[N];
            out_valid_next = 1'b1;
            matched_next = nxt_vec[eff_len];
            done_next = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        done_reg <= done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, matched_reg};
    assign m_tlast = done_reg;

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> act_vec == (N+1)'(1))
        else $error("active set not back at start after final byte");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted byte gave no result");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result is stalled");

    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tlast |=> m_tdata[0] == act_vec[$past(eff_len)])
        else $error("match flag differs from final position of stored set");

endmodule

FILE: src/wgm_cell.sv
module wgm_cell #(
    parameter logic START_BIT = 1'b0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           restart,
    input  logic           elem_en,
    input  logic           pos_en,
    input  wgm_pkg::kind_t kind,
    input  logic [7:0]     elem_byte,
    input  logic [7:0]     text_byte,
    input  wgm_pkg::link_t link_in,
    output wgm_pkg::link_t link_out,
    output logic           moved_pos,
    output logic           state
);
    import wgm_pkg::*;

    logic act_reg;
    logic act_next;
    logic cur;
    logic nxt;
    logic nxtc;
    logic is_run;
    logic moves;

    always_comb
    begin
        is_run = 1'b0;
        moves = 1'b0;
        unique case (kind)
            KIND_LITERAL: moves = (elem_byte == text_byte);
            KIND_ONE:     moves = 1'b1;
            KIND_RUN:     is_run = 1'b1;
            default:
            begin
                is_run = 1'b0;
                moves = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cur = (act_reg & pos_en) | link_in.cur_carry;
        nxt = link_in.step | (cur & is_run & elem_en);
        nxtc = nxt | link_in.nc_carry;
        link_out.cur_carry = cur & is_run & elem_en;
        link_out.step = cur & moves & elem_en;
        link_out.nc_carry = nxtc & is_run & elem_en;
        moved_pos = nxtc;
        state = act_reg;
    end

    always_comb
    begin
        act_next = act_reg;
        if (advance)
        begin
            act_next = restart ? START_BIT : nxtc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= START_BIT;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule
